// File: rtl/core/mkd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse key decoder package
// Shared widths, symbol class codes, register indexes and the letter table.
// ----------------------------------------------------------------------------
package mkd_pkg;

    localparam int BUFFER_SYMBOLS = 6;
    localparam int BITS_W         = BUFFER_SYMBOLS - 1;
    localparam int CNT_W          = $clog2(BUFFER_SYMBOLS);
    localparam int TICKS_W        = 16;
    localparam int LIMIT_W        = 16;
    localparam int CODE_W         = 7;
    localparam int CLASS_W        = 2;
    localparam int LETTER_COUNT   = 26;
    localparam int IN_TDATA_W     = 16;
    localparam int OUT_TDATA_W    = 16;
    localparam int CFG_INDEX_W    = 1;

    localparam logic [LIMIT_W-1:0] DOT_LIMIT_RESET  = 16'd1000;
    localparam logic [LIMIT_W-1:0] DASH_LIMIT_RESET = 16'd3000;

    localparam logic [CODE_W-1:0] CODE_BLANK        = 7'd32;
    localparam logic [CODE_W-1:0] CODE_FIRST_LETTER = 7'd65;

    localparam logic [CLASS_W-1:0] CLASS_DOT   = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_DASH  = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_SPACE = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_DOT_LIMIT  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DASH_LIMIT = 1'd1;

    // Symbol count and dash pattern (bit i is symbol i) of the letters A to Z.
    localparam logic [2:0] LETTER_LEN [LETTER_COUNT] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
        3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };
    localparam logic [3:0] LETTER_PAT [LETTER_COUNT] = '{
        4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14, 4'd5, 4'd2, 4'd3,
        4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1, 4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
    };

    typedef struct packed {
        logic [CLASS_W-1:0] symbol_class;
        logic               letter_valid;
        logic [CODE_W-1:0]  letter_code;
    } result_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] dot_limit;
        logic [LIMIT_W-1:0] dash_limit;
    } limits_t;

    function automatic logic [CODE_W-1:0] lookup_letter(
        input logic [CNT_W-1:0]  count,
        input logic [BITS_W-1:0] bits
    );
        logic [CODE_W-1:0] code;
        code = CODE_BLANK;
        for (int i = 0; i < LETTER_COUNT; i++) begin
            if (count == CNT_W'(LETTER_LEN[i]) && bits == BITS_W'(LETTER_PAT[i])) begin
                code = CODE_FIRST_LETTER + CODE_W'(i);
            end
        end
        return code;
    endfunction

endpackage

// File: rtl/core/morse_key_press_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse key press decoder
// Turns key press durations into dot, dash and space symbols and letters.
// ----------------------------------------------------------------------------
// Channel | Direction | Payload
// s_axis  | in        | press_ticks (16 bit)
// m_axis  | out       | symbol_class, letter_valid, letter_code
// cfg     | in        | register index, 16-bit limit value
//
// One item is taken per cycle while no result is stalled; its result passes
// the input register, then the result register, before it is valid on m_axis,
// and one result leaves per item.
// Reset clears the symbol buffer and restores the default limits.
// A stalled result holds both registers; the input side keeps accepting
// while the input register is empty or moving forward.
// ----------------------------------------------------------------------------
module morse_key_press_decoder (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [mkd_pkg::IN_TDATA_W-1:0]        s_tdata,   // [15:0] press_ticks
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [1:0] symbol_class, [2] letter_valid, [9:3] letter_code, [15:10] zero
    output logic [mkd_pkg::OUT_TDATA_W-1:0]       m_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mkd_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [mkd_pkg::LIMIT_W-1:0]           cfg_data
);
    import mkd_pkg::*;

    logic               in_valid_reg;
    logic [TICKS_W-1:0] in_ticks_reg;
    logic               out_valid_reg;
    result_t            out_result_reg;
    result_t            result;
    limits_t            limits;
    logic               step;

    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    mkd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .limits    (limits)
    );

    mkd_decode_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .press_ticks (in_ticks_reg),
        .limits      (limits),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (step) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_ticks_reg <= s_tdata[TICKS_W-1:0];
        end
        if (step) begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_result_reg.letter_code, out_result_reg.letter_valid,
                       out_result_reg.symbol_class};

endmodule

// File: rtl/core/mkd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse key decoder configuration registers
// Holds the dot and dash limits written through the configuration channel.
// ----------------------------------------------------------------------------
module mkd_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mkd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mkd_pkg::LIMIT_W-1:0]      cfg_data,
    output mkd_pkg::limits_t                 limits
);
    import mkd_pkg::*;

    logic [LIMIT_W-1:0] dot_limit_reg;
    logic [LIMIT_W-1:0] dash_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_limit_reg  <= DOT_LIMIT_RESET;
            dash_limit_reg <= DASH_LIMIT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_DOT_LIMIT:  dot_limit_reg  <= cfg_data;
                REG_DASH_LIMIT: dash_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign limits.dot_limit  = dot_limit_reg;
    assign limits.dash_limit = dash_limit_reg;

endmodule

// File: rtl/core/mkd_decode_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse key decoder core
// Classifies one press, updates the symbol buffer and looks up the letter.
// ----------------------------------------------------------------------------
module mkd_decode_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  logic [mkd_pkg::TICKS_W-1:0]  press_ticks,
    input  mkd_pkg::limits_t             limits,
    output mkd_pkg::result_t             result
);
    import mkd_pkg::*;

    logic               long_seen_reg, long_seen_next;
    logic [BITS_W-1:0]  bits_reg, bits_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CLASS_W-1:0] cls;
    logic [BITS_W-1:0]  appended;

    always_comb begin
        long_seen_next = long_seen_reg;
        if (long_seen_reg) begin
            long_seen_next = 1'b0;
            cls            = CLASS_SPACE;
        end else if (press_ticks < limits.dot_limit) begin
            cls = CLASS_DOT;
        end else if (press_ticks < limits.dash_limit) begin
            cls = CLASS_DASH;
        end else begin
            long_seen_next = 1'b1;
            cls            = CLASS_SPACE;
        end

        appended = bits_reg | (BITS_W'(cls == CLASS_DASH) << count_reg);

        result.symbol_class = cls;
        result.letter_valid = 1'b0;
        result.letter_code  = '0;
        bits_next  = bits_reg;
        count_next = count_reg;
        if (cls == CLASS_SPACE) begin
            result.letter_valid = 1'b1;
            result.letter_code  = lookup_letter(count_reg, bits_reg);
            bits_next  = '0;
            count_next = '0;
        end else if (count_reg == CNT_W'(BUFFER_SYMBOLS - 1)) begin
            // A full buffer drops everything collected so far.
            bits_next  = '0;
            count_next = '0;
        end else begin
            bits_next  = appended;
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_seen_reg <= 1'b0;
            bits_reg      <= '0;
            count_reg     <= '0;
        end else if (step) begin
            long_seen_reg <= long_seen_next;
            bits_reg      <= bits_next;
            count_reg     <= count_next;
        end
    end

endmodule
